>>> rtl/bbd_pkg.sv
// bbd_pkg: shared types and constants of the border box detector
// no dependencies; imported by every module of the block
package bbd_pkg;

  localparam int CFG_W     = 9;  // width of the side and band registers
  localparam int LEVEL_W   = 8;
  localparam int CHAN_W    = 8;
  localparam int SIDES_W   = 3;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_THICKNESS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_LEVEL    = 2'd3;

  localparam logic [CFG_W-1:0]   RST_SQUARE_WIDTH   = 9'd64;
  localparam logic [CFG_W-1:0]   RST_SQUARE_HEIGHT  = 9'd64;
  localparam logic [CFG_W-1:0]   RST_BAND_THICKNESS = 9'd5;
  localparam logic [LEVEL_W-1:0] RST_WHITE_LEVEL    = 8'd160;

  localparam logic [SIDES_W-1:0] BOX_MIN_SIDES = 3'd2;

  // width that holds both a full side length and a configuration value
  function automatic int bbd_ext_w(input int max_side);
    int sw;
    begin
      sw = $clog2(max_side + 1);
      return (sw > CFG_W) ? sw : CFG_W;
    end
  endfunction

  // per-pixel flags handed from the position stage to the band update stage
  typedef struct packed {
    logic white;
    logic first_pix;   // column 0, row 0: clears the hit counts
    logic col0;        // first column: clears the row seen flags
    logic in_top;
    logic top_first;
    logic top_last;
    logic in_bot;
    logic bot_first;
    logic bot_last;
    logic in_left;
    logic left_last;
    logic in_right;
    logic right_last;
    logic last;        // last pixel of the square: emits a result
  } pix_flags_t;

  typedef struct packed {
    logic               box_found;
    logic [SIDES_W-1:0] sides_found;
  } result_t;

endpackage

>>> rtl/border_box_detector.sv
// border_box_detector: white outline box detection over one board square
// result path: the last pixel's flags are registered, then its result is queued and presented
// throughput: one pixel per cycle while the result queue has room, set by the read-modify-write of the
//   band column memory (one read and one write port, forwarding on back-to-back hits)
// reset: synchronous active-low; clears counters and queue, loads register defaults,
//   band column memory is not cleared and needs no sweep
module border_box_detector
  import bbd_pkg::*;
#(
  parameter int MAX_SQUARE_SIDE = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // pixel input
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // blue [7:0], green [15:8], red [23:16]
  input  logic                 in_tuser,   // start_of_square [0]
  // result output
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // sides_found [2:0], box_found [3], zero [7:4]
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int POS_W = $clog2(MAX_SQUARE_SIDE);
  localparam int EXT_W = bbd_ext_w(MAX_SQUARE_SIDE);

  // configuration registers
  logic [CFG_W-1:0]   square_width_r;
  logic [CFG_W-1:0]   square_height_r;
  logic [CFG_W-1:0]   band_thickness_r;
  logic [LEVEL_W-1:0] white_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      square_width_r   <= RST_SQUARE_WIDTH;
      square_height_r  <= RST_SQUARE_HEIGHT;
      band_thickness_r <= RST_BAND_THICKNESS;
      white_level_r    <= RST_WHITE_LEVEL;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SQUARE_WIDTH:   square_width_r   <= cfg_data;
        CFG_SQUARE_HEIGHT:  square_height_r  <= cfg_data;
        CFG_BAND_THICKNESS: band_thickness_r <= cfg_data;
        CFG_WHITE_LEVEL:    white_level_r    <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry: zero side taken as one, large sides saturate,
  // band thickness limited to the side it lies across
  function automatic logic [EXT_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
    logic [EXT_W-1:0] ve;
    begin
      ve = EXT_W'(v);
      if (ve == '0) begin
        return EXT_W'(1);
      end else if (ve > EXT_W'(MAX_SQUARE_SIDE)) begin
        return EXT_W'(MAX_SQUARE_SIDE);
      end
      return ve;
    end
  endfunction

  logic [EXT_W-1:0] side_w, side_h, thick_e, thick_c, thick_r;

  always_comb begin
    side_w  = clamp_side(square_width_r);
    side_h  = clamp_side(square_height_r);
    thick_e = EXT_W'(band_thickness_r);
    thick_c = (thick_e < side_w) ? thick_e : side_w;
    thick_r = (thick_e < side_h) ? thick_e : side_h;
  end

  // input transaction
  logic accept;
  assign accept = in_tvalid && in_tready;

  logic [POS_W-1:0] rd_addr;
  logic             s1_valid;
  pix_flags_t       s1_flags;
  logic [POS_W-1:0] s1_idx;

  bbd_pos_ctrl #(
    .MAX_SQUARE_SIDE (MAX_SQUARE_SIDE)
  ) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .start       (in_tuser),
    .blue        (in_tdata[7:0]),
    .green       (in_tdata[15:8]),
    .red         (in_tdata[23:16]),
    .white_level (white_level_r),
    .side_w      (side_w),
    .side_h      (side_h),
    .thick_c     (thick_c),
    .thick_r     (thick_r),
    .rd_addr     (rd_addr),
    .s1_valid_r  (s1_valid),
    .s1_flags_r  (s1_flags),
    .s1_idx_r    (s1_idx)
  );

  // band stage: memory read issued with the transaction, updated in the following cycle
  logic    res_valid;
  result_t res;

  bbd_band_update #(
    .MAX_SQUARE_SIDE (MAX_SQUARE_SIDE)
  ) u_band (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_addr   (rd_addr),
    .s1_valid  (s1_valid),
    .s1_flags  (s1_flags),
    .s1_idx    (s1_idx),
    .side_w    (side_w),
    .side_h    (side_h),
    .res_valid (res_valid),
    .res       (res)
  );

  // result queue; the band stage never stalls, so a pixel is taken only when
  // a queue slot is guaranteed for it and for the result already in flight,
  // counting the slot freed by a result transaction in the same cycle
  logic       head_valid;
  result_t    head_data;
  logic [1:0] level;
  logic       out_pop;
  logic [2:0] committed;

  bbd_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .pop_ready  (out_tready),
    .head_valid (head_valid),
    .head_data  (head_data),
    .level      (level)
  );

  assign out_pop    = head_valid && out_tready;
  assign committed  = 3'(level) + 3'(res_valid) - 3'(out_pop);
  assign in_tready  = committed <= 3'd1;
  assign out_tvalid = head_valid;
  assign out_tdata  = {4'b0000, head_data.box_found, head_data.sides_found};

endmodule

>>> rtl/bbd_pos_ctrl.sv
// bbd_pos_ctrl: column and row counters, white test and band membership flags
// depends on bbd_pkg
module bbd_pos_ctrl
  import bbd_pkg::*;
#(
  parameter int MAX_SQUARE_SIDE = 256
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   accept,
  input  logic                                   start,
  input  logic [CHAN_W-1:0]                      blue,
  input  logic [CHAN_W-1:0]                      green,
  input  logic [CHAN_W-1:0]                      red,
  input  logic [LEVEL_W-1:0]                     white_level,
  input  logic [bbd_ext_w(MAX_SQUARE_SIDE)-1:0]  side_w,
  input  logic [bbd_ext_w(MAX_SQUARE_SIDE)-1:0]  side_h,
  input  logic [bbd_ext_w(MAX_SQUARE_SIDE)-1:0]  thick_c,
  input  logic [bbd_ext_w(MAX_SQUARE_SIDE)-1:0]  thick_r,
  output logic [$clog2(MAX_SQUARE_SIDE)-1:0]     rd_addr,
  output logic                                   s1_valid_r,
  output pix_flags_t                             s1_flags_r,
  output logic [$clog2(MAX_SQUARE_SIDE)-1:0]     s1_idx_r
);

  localparam int POS_W = $clog2(MAX_SQUARE_SIDE);
  localparam int EXT_W = bbd_ext_w(MAX_SQUARE_SIDE);

  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  logic [POS_W-1:0] col, row;
  logic [EXT_W-1:0] col_e, row_e;
  logic             last_col, last_row;
  pix_flags_t       flags;

  always_comb begin
    col   = start ? '0 : col_r;
    row   = start ? '0 : row_r;
    col_e = EXT_W'(col);
    row_e = EXT_W'(row);

    last_col = col_e >= side_w - EXT_W'(1);
    last_row = row_e >= side_h - EXT_W'(1);

    flags.white      = (blue >= white_level) && (green >= white_level) &&
                       (red >= white_level);
    flags.first_pix  = (col == '0) && (row == '0);
    flags.col0       = (col == '0);
    flags.in_top     = row_e < thick_r;
    flags.top_first  = (row == '0);
    flags.top_last   = row_e == thick_r - EXT_W'(1);
    flags.in_bot     = (thick_r != '0) && (row_e >= side_h - thick_r) && (row_e < side_h);
    flags.bot_first  = row_e == side_h - thick_r;
    flags.bot_last   = row_e == side_h - EXT_W'(1);
    flags.in_left    = col_e < thick_c;
    flags.left_last  = col_e == thick_c - EXT_W'(1);
    flags.in_right   = (thick_c != '0) && (col_e >= side_w - thick_c) && (col_e < side_w);
    flags.right_last = col_e == side_w - EXT_W'(1);
    flags.last       = last_col && last_row;

    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row + POS_W'(1);
      end else begin
        col_nxt = col + POS_W'(1);
        row_nxt = row;
      end
    end
  end

  assign rd_addr = col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags_r <= flags;
      s1_idx_r   <= col;
    end
  end

endmodule

>>> rtl/bbd_band_update.sv
// bbd_band_update: band column memory read-modify-write, hit counters, side vote
// depends on bbd_pkg
module bbd_band_update
  import bbd_pkg::*;
#(
  parameter int MAX_SQUARE_SIDE = 256
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   rd_en,
  input  logic [$clog2(MAX_SQUARE_SIDE)-1:0]     rd_addr,
  input  logic                                   s1_valid,
  input  pix_flags_t                             s1_flags,
  input  logic [$clog2(MAX_SQUARE_SIDE)-1:0]     s1_idx,
  input  logic [bbd_ext_w(MAX_SQUARE_SIDE)-1:0]  side_w,
  input  logic [bbd_ext_w(MAX_SQUARE_SIDE)-1:0]  side_h,
  output logic                                   res_valid,
  output result_t                                res
);

  localparam int POS_W = $clog2(MAX_SQUARE_SIDE);
  localparam int EXT_W = bbd_ext_w(MAX_SQUARE_SIDE);
  localparam int CNT_W = $clog2(MAX_SQUARE_SIDE + 1);
  localparam int CMP_W = (CNT_W + 4 > EXT_W) ? CNT_W + 4 : EXT_W;

  // bit 0: top band column, bit 1: bottom band column
  logic [1:0] band_mem [MAX_SQUARE_SIDE];
  logic [1:0] rd_data_r;

  logic             wr_vld_r;
  logic [POS_W-1:0] wr_addr_r;
  logic [1:0]       wr_data_r;

  logic [CNT_W-1:0] top_cnt_r, top_cnt_nxt;
  logic [CNT_W-1:0] bot_cnt_r, bot_cnt_nxt;
  logic [CNT_W-1:0] left_cnt_r, left_cnt_nxt;
  logic [CNT_W-1:0] right_cnt_r, right_cnt_nxt;
  logic             left_seen_r, left_seen_nxt;
  logic             right_seen_r, right_seen_nxt;

  logic [1:0]       cur;
  logic [1:0]       wr_data;
  logic             wr_en;
  logic             top_v, bot_v;
  logic [CNT_W-1:0] top_base, bot_base, left_base, right_base;
  logic             left_base_seen, right_base_seen;
  logic             top_hit, bot_hit, left_hit, right_hit;

  function automatic logic side_hit(input logic [CNT_W-1:0] cnt,
                                    input logic [EXT_W-1:0] side);
    logic [CMP_W-1:0] ten;
    begin
      ten = (CMP_W'(cnt) << 3) + (CMP_W'(cnt) << 1);
      return ten > CMP_W'(side);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= band_mem[rd_addr];
    end
    if (wr_en) begin
      band_mem[s1_idx] <= wr_data;
    end
  end

  always_comb begin
    // the previous pixel's write may not have reached the read port yet
    cur = (wr_vld_r && (wr_addr_r == s1_idx)) ? wr_data_r : rd_data_r;

    top_v = s1_flags.white || (!s1_flags.top_first && cur[0]);
    bot_v = s1_flags.white || (!s1_flags.bot_first && cur[1]);

    wr_en   = s1_valid && (s1_flags.in_top || s1_flags.in_bot);
    wr_data = {s1_flags.in_bot ? bot_v : cur[1], s1_flags.in_top ? top_v : cur[0]};

    top_base   = s1_flags.first_pix ? '0 : top_cnt_r;
    bot_base   = s1_flags.first_pix ? '0 : bot_cnt_r;
    left_base  = s1_flags.first_pix ? '0 : left_cnt_r;
    right_base = s1_flags.first_pix ? '0 : right_cnt_r;

    left_base_seen  = s1_flags.col0 ? 1'b0 : left_seen_r;
    right_base_seen = s1_flags.col0 ? 1'b0 : right_seen_r;

    left_seen_nxt  = s1_flags.in_left  ? (left_base_seen  || s1_flags.white) : left_base_seen;
    right_seen_nxt = s1_flags.in_right ? (right_base_seen || s1_flags.white) : right_base_seen;

    top_hit   = s1_flags.in_top   && s1_flags.top_last   && top_v;
    bot_hit   = s1_flags.in_bot   && s1_flags.bot_last   && bot_v;
    left_hit  = s1_flags.in_left  && s1_flags.left_last  && left_seen_nxt;
    right_hit = s1_flags.in_right && s1_flags.right_last && right_seen_nxt;

    top_cnt_nxt   = top_base   + CNT_W'(top_hit);
    bot_cnt_nxt   = bot_base   + CNT_W'(bot_hit);
    left_cnt_nxt  = left_base  + CNT_W'(left_hit);
    right_cnt_nxt = right_base + CNT_W'(right_hit);

    res.sides_found = SIDES_W'(side_hit(top_cnt_nxt, side_w)) +
                      SIDES_W'(side_hit(bot_cnt_nxt, side_w)) +
                      SIDES_W'(side_hit(left_cnt_nxt, side_h)) +
                      SIDES_W'(side_hit(right_cnt_nxt, side_h));
    res.box_found   = res.sides_found >= BOX_MIN_SIDES;
    res_valid       = s1_valid && s1_flags.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_vld_r     <= 1'b0;
      top_cnt_r    <= '0;
      bot_cnt_r    <= '0;
      left_cnt_r   <= '0;
      right_cnt_r  <= '0;
      left_seen_r  <= 1'b0;
      right_seen_r <= 1'b0;
    end else begin
      wr_vld_r <= wr_en;
      if (s1_valid) begin
        top_cnt_r    <= top_cnt_nxt;
        bot_cnt_r    <= bot_cnt_nxt;
        left_cnt_r   <= left_cnt_nxt;
        right_cnt_r  <= right_cnt_nxt;
        left_seen_r  <= left_seen_nxt;
        right_seen_r <= right_seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wr_addr_r <= s1_idx;
      wr_data_r <= wr_data;
    end
  end

endmodule

>>> rtl/bbd_out_fifo.sv
// bbd_out_fifo: two-entry result queue between the band stage and the output port
// depends on bbd_pkg
module bbd_out_fifo
  import bbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop_ready,
  output logic    head_valid,
  output result_t head_data,
  output logic [1:0] level
);

  logic [1:0] cnt_r, cnt_nxt;
  result_t    ent0_r, ent1_r;
  logic       pop;
  logic [1:0] slot;

  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = ent0_r;
  assign level      = cnt_r;
  assign pop        = head_valid && pop_ready;
  assign slot       = cnt_r - 2'(pop);
  assign cnt_nxt    = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && (slot == 2'd0)) begin
      ent0_r <= push_data;
    end else if (pop) begin
      ent0_r <= ent1_r;
    end
    if (push && (slot != 2'd0)) begin
      ent1_r <= push_data;
    end
  end

endmodule

>>> verif/border_box_detector_test.sv
// border_box_detector_test: self-checking bench for the border box detector
// drives pixel transactions and register writes, predicts each square result and
// compares it with the output stream; depends on bbd_pkg and border_box_detector
module border_box_detector_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bbd_pkg::*;

  localparam int MAX_SIDE       = 256;
  localparam int SETTLE_CYCLES  = 4;     // extra wait once every result has arrived
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transaction on either side

  // clock, reset and the block's ports; the ones the bench drives are known from time zero
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [23:0]          in_tdata  = '0;   // blue [7:0], green [15:8], red [23:16]
  logic                 in_tuser  = 1'b0; // start_of_square [0]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;        // sides_found [2:0], box_found [3], zero [7:4]
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  border_box_detector #(.MAX_SQUARE_SIDE(MAX_SIDE)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // square scorer: the bench's own copy of registers and band state
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]   reg_width  = RST_SQUARE_WIDTH;
  logic [CFG_W-1:0]   reg_height = RST_SQUARE_HEIGHT;
  logic [CFG_W-1:0]   reg_band   = RST_BAND_THICKNESS;
  logic [LEVEL_W-1:0] reg_level  = RST_WHITE_LEVEL;

  // effective sizes after clamping, refreshed on every register write
  int eff_w, eff_h, eff_tc, eff_tr;

  bit         top_marks    [MAX_SIDE];  // column has white somewhere in the top band
  bit         bottom_marks [MAX_SIDE];
  logic [7:0] pos_col   = '0;
  logic [7:0] pos_row   = '0;
  logic [8:0] top_hits  = '0;
  logic [8:0] bot_hits  = '0;
  logic [8:0] left_hits = '0;
  logic [8:0] right_hits = '0;
  bit         left_seen  = 1'b0;
  bit         right_seen = 1'b0;

  result_t     expected_results [$];
  int          errors;
  int unsigned pixels_sent, squares_sent, results_checked, settings_used;
  int          quiet_cycles;
  bit          no_idle;  // both sides run without gaps while set

  // zero reads as one, anything past the largest side saturates
  function automatic int side_length(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  function automatic void refresh_sizes();
    eff_w  = side_length(reg_width);
    eff_h  = side_length(reg_height);
    eff_tc = (int'(reg_band) < eff_w) ? int'(reg_band) : eff_w;
    eff_tr = (int'(reg_band) < eff_h) ? int'(reg_band) : eff_h;
  endfunction

  // advance the band state by one pixel; returns 1 when the pixel ends a square
  function automatic bit score_pixel(input bit sos, input logic [7:0] b, g, r,
                                     output result_t res);
    int  col, row, sides;
    bit  white, v, last_col, last_row;
    white = (b >= reg_level) && (g >= reg_level) && (r >= reg_level);
    if (sos) begin
      pos_col = '0;
      pos_row = '0;
    end
    col = int'(pos_col);
    row = int'(pos_row);
    // first pixel of a square starts all four counts over
    if (col == 0 && row == 0) begin
      top_hits   = '0;
      bot_hits   = '0;
      left_hits  = '0;
      right_hits = '0;
    end
    // top band: or the column down the band, count on its last row
    if (row < eff_tr) begin
      v = white || (row != 0 && top_marks[col]);
      top_marks[col] = v;
      if (row == eff_tr - 1 && v) top_hits++;
    end
    if (eff_tr != 0 && row >= eff_h - eff_tr && row < eff_h) begin
      v = white || (row != eff_h - eff_tr && bottom_marks[col]);
      bottom_marks[col] = v;
      if (row == eff_h - 1 && v) bot_hits++;
    end
    // left and right bands are judged once per row
    if (col == 0) begin
      left_seen  = 1'b0;
      right_seen = 1'b0;
    end
    if (col < eff_tc) begin
      left_seen = left_seen || white;
      if (col == eff_tc - 1 && left_seen) left_hits++;
    end
    if (eff_tc != 0 && col >= eff_w - eff_tc && col < eff_w) begin
      right_seen = right_seen || white;
      if (col == eff_w - 1 && right_seen) right_hits++;
    end
    last_col = col >= eff_w - 1;
    last_row = row >= eff_h - 1;
    res = '0;
    score_pixel = 1'b0;
    if (last_col && last_row) begin
      // a side counts above ten percent coverage: 10 * hits > side
      sides = 0;
      if (10 * int'(top_hits)   > eff_w) sides++;
      if (10 * int'(bot_hits)   > eff_w) sides++;
      if (10 * int'(left_hits)  > eff_h) sides++;
      if (10 * int'(right_hits) > eff_h) sides++;
      res.sides_found = SIDES_W'(sides);
      res.box_found   = (SIDES_W'(sides) >= BOX_MIN_SIDES);
      score_pixel = 1'b1;
    end
    // a position at or past the end closes the row (and the square)
    if (last_col) begin
      pos_col = '0;
      pos_row = last_row ? 8'd0 : 8'(row + 1);
    end else begin
      pos_col = 8'(col + 1);
    end
  endfunction

  // pixel that is white or not at the current level; boundary values show up often
  function automatic logic [23:0] make_pixel(input bit want_white);
    logic [7:0] ch [3];
    int k;
    for (k = 0; k < 3; k++) begin
      ch[k] = want_white ? 8'($urandom_range(255, reg_level)) : 8'($urandom);
    end
    if (want_white && $urandom_range(0, 3) == 0) ch[$urandom_range(0, 2)] = reg_level;
    if (!want_white && reg_level != 0) begin
      k = $urandom_range(0, 2);
      ch[k] = ($urandom_range(0, 3) == 0) ? reg_level - 8'd1
                                           : 8'($urandom_range(reg_level - 1, 0));
    end
    return {ch[2], ch[1], ch[0]};
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 5;
      2:       return 15;
      3:       return 40;
      default: return 100;
    endcase
  endfunction

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one pixel transaction; valid stays up across back-to-back pixels
  task automatic send_pixel(input bit sos, input logic [23:0] pix, output bit ended);
    int      gap;
    result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= sos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
    ended = score_pixel(sos, pix[7:0], pix[15:8], pix[23:16], res);
    if (ended) expected_results.push_back(res);
  endtask

  // drop valid, wait for every expected result, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SQUARE_WIDTH:   reg_width  = value;
      CFG_SQUARE_HEIGHT:  reg_height = value;
      CFG_BAND_THICKNESS: reg_band   = value;
      CFG_WHITE_LEVEL:    reg_level  = value[LEVEL_W-1:0];
      default: ;
    endcase
    refresh_sizes();
  endtask

  // all four registers; bit 8 of the level write is junk that must be dropped
  task automatic apply_setting(input int w, h, t, lvl);
    write_reg(CFG_SQUARE_WIDTH,   CFG_W'(w));
    write_reg(CFG_SQUARE_HEIGHT,  CFG_W'(h));
    write_reg(CFG_BAND_THICKNESS, CFG_W'(t));
    write_reg(CFG_WHITE_LEVEL,    {1'($urandom), LEVEL_W'(lvl)});
    settings_used++;
  endtask

  // pixels until the scorer sees the square end; white density set per band
  task automatic send_square(input int pct_top, pct_bot, pct_left, pct_right, pct_back,
                             input bit lead_start, input int restart_pm);
    bit ended, sos;
    int pct, c, r;
    ended = 1'b0;
    sos   = lead_start;
    while (!ended) begin
      c = sos ? 0 : int'(pos_col);
      r = sos ? 0 : int'(pos_row);
      pct = pct_back;
      if (r < eff_tr && pct_top > pct) pct = pct_top;
      if (r >= eff_h - eff_tr && r < eff_h && pct_bot > pct) pct = pct_bot;
      if (c < eff_tc && pct_left > pct) pct = pct_left;
      if (c >= eff_w - eff_tc && c < eff_w && pct_right > pct) pct = pct_right;
      send_pixel(sos, make_pixel($urandom_range(1, 100) <= pct), ended);
      // occasional restart in the middle of a square
      sos = ($urandom_range(1, 1000) <= restart_pm);
    end
    squares_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall drawn per result transaction
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    @(posedge rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        report($sformatf("result %h with no square pending", out_tdata));
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[2:0] !== want.sides_found)
          report($sformatf("sides_found %0d, predicted %0d", out_tdata[2:0], want.sides_found));
        if (out_tdata[3] !== want.box_found)
          report($sformatf("box_found %b, predicted %b", out_tdata[3], want.box_found));
        if (out_tdata[7:4] !== 4'd0)
          report($sformatf("pad bits %h not zero", out_tdata[7:4]));
      end
    end
  end

  // watchdog: too long without any transaction means the block hung
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // 1x1 squares: zero sizes read as one, default thickness clamps, level compares
  task automatic test_single_pixel_squares();
    bit ended;
    write_reg(CFG_SQUARE_WIDTH, '0);
    write_reg(CFG_SQUARE_HEIGHT, '0);
    send_pixel(1'b1, {8'hff, 8'hff, 8'hff}, ended);
    send_pixel(1'b0, {8'd160, 8'd160, 8'd160}, ended);   // exactly at the level
    send_pixel(1'b0, {8'd160, 8'd160, 8'd159}, ended);   // blue just below
    send_pixel(1'b1, {8'd160, 8'd159, 8'd160}, ended);   // green just below
    send_pixel(1'b0, {8'd159, 8'd160, 8'd160}, ended);   // red just below
    send_pixel(1'b0, {8'h00, 8'h00, 8'h00}, ended);
    settle();
    // zero thickness: no bands at all, nothing can count
    write_reg(CFG_BAND_THICKNESS, '0);
    send_pixel(1'b1, {8'hff, 8'hff, 8'hff}, ended);
    settle();
  endtask

  // 2x2 squares at both level extremes
  task automatic test_tiny_squares();
    bit ended;
    apply_setting(2, 2, 2, 0);  // level zero: every pixel white
    send_pixel(1'b1, 24'h000000, ended);
    send_pixel(1'b0, 24'h000000, ended);
    send_pixel(1'b0, 24'h000000, ended);
    send_pixel(1'b0, 24'h000000, ended);
    settle();
    apply_setting(2, 2, 1, 255);  // only full white counts, top-left corner only
    send_pixel(1'b1, 24'hffffff, ended);
    send_pixel(1'b0, 24'hfffffe, ended);
    send_pixel(1'b0, 24'h000000, ended);
    send_pixel(1'b0, 24'hfeffff, ended);
    settle();
  endtask

  // start marker in the middle of a square restarts it
  task automatic test_restart_mid_square();
    bit ended;
    apply_setting(2, 2, 2, 128);
    send_pixel(1'b1, 24'hffffff, ended);
    send_pixel(1'b0, 24'h101010, ended);
    send_pixel(1'b1, 24'h101010, ended);
    send_pixel(1'b0, 24'hc0c0c0, ended);
    send_pixel(1'b0, 24'h101010, ended);
    send_pixel(1'b0, 24'h808080, ended);
    settle();
  endtask

  // shrink width, then height, while a square is half done
  task automatic test_position_past_end();
    bit ended;
    int k;
    apply_setting(16, 4, 3, 128);
    for (k = 0; k < 10; k++) send_pixel(k == 0, make_pixel(1'($urandom)), ended);
    settle();
    // column 10 is now past the last column and closes row 0
    write_reg(CFG_SQUARE_WIDTH, 9'd8);
    send_square(40, 40, 40, 40, 10, 1'b0, 0);
    settle();
    apply_setting(6, 8, 3, 128);
    for (k = 0; k < 30; k++) send_pixel(k == 0, make_pixel(1'($urandom)), ended);
    settle();
    // row 5 is past the last row: its end closes the square
    write_reg(CFG_SQUARE_HEIGHT, 9'd3);
    send_square(40, 40, 40, 40, 10, 1'b0, 0);
    settle();
  endtask

  // oversized registers saturate to the largest side; one row and one column
  task automatic test_largest_squares();
    no_idle = 1'b1;
    apply_setting(511, 1, 511, $urandom_range(0, 255));
    send_square(15, 15, 100, 100, 5, 1'b1, 0);
    settle();
    no_idle = 1'b0;
    apply_setting(1, 511, 256, $urandom_range(0, 255));
    send_square(100, 100, 15, 15, 5, 1'b1, 0);
    settle();
  endtask

  // random small squares with random settings; each setting change drains first
  task automatic test_random_squares();
    int unsigned first_pixel, first_square;
    int w, h, t, lvl;
    first_pixel  = pixels_sent;
    first_square = squares_sent;
    while (pixels_sent - first_pixel < 440 || squares_sent - first_square < 20) begin
      settle();
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : $urandom_range(1, 6);
      h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : $urandom_range(1, 6);
      case ($urandom_range(0, 9))
        0, 1:    t = $urandom_range(0, 2);
        2:       t = ($urandom_range(0, 1) == 0) ? 511 : $urandom_range(256, 511);
        default: t = $urandom_range(3, 16);
      endcase
      case ($urandom_range(0, 9))
        0:       lvl = 0;
        1:       lvl = 255;
        default: lvl = $urandom_range(0, 255);
      endcase
      apply_setting(w, h, t, lvl);
      repeat ($urandom_range(1, 4)) begin
        no_idle = ($urandom_range(0, 3) == 0);
        send_square(pick_pct(), pick_pct(), pick_pct(), pick_pct(),
                    ($urandom_range(0, 2) == 0) ? $urandom_range(0, 100) : 0,
                    $urandom_range(0, 4) != 0,
                    ($urandom_range(0, 4) == 0) ? 30 : 0);
      end
    end
    no_idle = 1'b0;
    settle();
  endtask

  initial begin
    refresh_sizes();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_single_pixel_squares();
    test_tiny_squares();
    test_restart_mid_square();
    test_position_past_end();
    test_largest_squares();
    test_random_squares();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report($sformatf("%0d square results never arrived", expected_results.size()));
    $display("ran %0d pixel transactions in %0d squares, %0d results compared",
             pixels_sent, squares_sent, results_checked);
    $display("over %0d register settings, with mid-square restarts and size changes",
             settings_used);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
